FILE: sv/mfub_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfub_pkg
// shared constants, codes and the queue entry type of the frame upscaler
// ----------------------------------------------------------------------------
package mfub_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 80;
  localparam int DISPLAY_HEIGHT_DEF = 64;
  localparam int SOURCE_WIDTH_DEF   = 64;
  localparam int SOURCE_HEIGHT_DEF  = 32;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // fixed widths of the word fields
  localparam int ADDR_W  = 11;
  localparam int COLOR_W = 32;
  localparam int PIXEL_W = 16;

  // wide enough for any source index (256 x 256)
  localparam int INDEX_W = 18;

  // item codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EMIT  = 1'b1;

  // one pending display pixel
  typedef struct packed {
    logic               lit;
    logic               overlay_enable;
    logic [COLOR_W-1:0] overlay_color;
    logic               frame_last;
  } mfub_entry_t;

  // push side of the queue
  typedef struct packed {
    logic        valid;
    mfub_entry_t entry;
  } mfub_push_t;

endpackage : mfub_pkg
`default_nettype wire

FILE: sv/mono_frame_upscale_overlay_blend_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mono_frame_upscale_overlay_blend_unit
// one-bit source frame centered in an rgb565 display scan, with overlay blend
// ----------------------------------------------------------------------------
// path: an emit word's pixel passes the source ram read, the queue and the
//   blend/output register; write words give nothing
// throughput: one word per cycle while in_ready is high, set by the single ram
//   port pair and the one-pixel-per-cycle blend; a 4-entry queue decouples the two sides
// reset: scan counters go to zero, then a clearing pass zeroes the source
//   frame, all SOURCE_WIDTH*SOURCE_HEIGHT cells (2048 by default), with in_ready low
// ----------------------------------------------------------------------------
module mono_frame_upscale_overlay_blend_unit
  import mfub_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF,
  parameter int SOURCE_WIDTH   = SOURCE_WIDTH_DEF,
  parameter int SOURCE_HEIGHT  = SOURCE_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic [ADDR_W-1:0]  source_address,
  input  wire logic               source_bit,
  input  wire logic               overlay_enable,
  input  wire logic [COLOR_W-1:0] overlay_color,
  // output words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PIXEL_W-1:0]      display_word,
  output logic                    frame_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // front to queue: one pixel per emit word, lit bit already resolved
  mfub_push_t    push;
  // queue to back
  logic          q_valid;
  mfub_entry_t   q_entry;
  logic          pop;
  // queue fill level, used by the front for credit
  logic [CW-1:0] q_count;

  // front: classify words, update source frame, scan and read the source bit
  mfub_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .SOURCE_WIDTH   (SOURCE_WIDTH),
    .SOURCE_HEIGHT  (SOURCE_HEIGHT),
    .CW             (CW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .source_address (source_address),
    .source_bit     (source_bit),
    .overlay_enable (overlay_enable),
    .overlay_color  (overlay_color),
    .q_count        (q_count),
    .push           (push)
  );

  // pending pixels, lets the output stall without stopping writes at once
  mfub_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (pop),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .count   (q_count)
  );

  // back: blend with the overlay, swap bytes, hold the output word
  mfub_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .display_word (display_word),
    .frame_last   (frame_last)
  );

endmodule : mono_frame_upscale_overlay_blend_unit
`default_nettype wire

FILE: sv/mfub_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfub_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module mfub_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mfub_ram
`default_nettype wire

FILE: sv/mfub_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfub_queue
// small fifo of pending pixels between front and back
// ----------------------------------------------------------------------------
module mfub_queue
  import mfub_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int PW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mfub_push_t  push,
  input  wire logic        pop,
  output logic             q_valid,
  output mfub_entry_t      q_entry,
  output logic [CW-1:0]    count
);

  mfub_entry_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push.valid && !pop |-> count < CW'(DEPTH))
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");

  a_count_up : assert property (@(posedge clk) disable iff (rst)
    push.valid && !pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a push");

endmodule : mfub_queue
`default_nettype wire

FILE: sv/mfub_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfub_front
// accepts words, writes the source frame, scans the display and reads the
// source bit for each emitted pixel
// ----------------------------------------------------------------------------
module mfub_front
  import mfub_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF,
  parameter int SOURCE_WIDTH   = SOURCE_WIDTH_DEF,
  parameter int SOURCE_HEIGHT  = SOURCE_HEIGHT_DEF,
  parameter int CW             = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic [ADDR_W-1:0]  source_address,
  input  wire logic               source_bit,
  input  wire logic               overlay_enable,
  input  wire logic [COLOR_W-1:0] overlay_color,
  input  wire logic [CW-1:0]      q_count,
  output mfub_push_t              push
);

  localparam int Cells   = SOURCE_WIDTH * SOURCE_HEIGHT;
  localparam int AW      = $clog2(Cells);
  localparam int ColW    = $clog2(DISPLAY_WIDTH);
  localparam int RowW    = $clog2(DISPLAY_HEIGHT);
  localparam int WinLeft = (DISPLAY_WIDTH - SOURCE_WIDTH) / 2;
  localparam int WinTop  = (DISPLAY_HEIGHT - SOURCE_HEIGHT) / 2;

  localparam logic [AW-1:0]      LastCell = AW'(Cells - 1);
  localparam logic [ColW-1:0]    LastCol  = ColW'(DISPLAY_WIDTH - 1);
  localparam logic [RowW-1:0]    LastRow  = RowW'(DISPLAY_HEIGHT - 1);
  localparam logic [INDEX_W-1:0] CellsW   = INDEX_W'(Cells);
  localparam logic signed [9:0]  WinLeftS = 10'(WinLeft);
  localparam logic signed [9:0]  WinTopS  = 10'(WinTop);
  localparam logic signed [9:0]  SrcWS    = 10'(SOURCE_WIDTH);
  localparam logic signed [9:0]  SrcHS    = 10'(SOURCE_HEIGHT);

  // clearing pass state
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // scan position
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;

  // read stage
  logic               s1_valid;
  logic               s1_in_win;
  logic               s1_ov_en;
  logic [COLOR_W-1:0] s1_ov_color;
  logic               s1_last;

  logic               accept;
  logic               write_acc;
  logic               emit_acc;
  logic [CW:0]        occupancy;
  logic [INDEX_W-1:0] addr_ext;
  logic               in_range;
  logic signed [9:0]  sx;
  logic signed [9:0]  sy;
  logic               in_win;
  logic [INDEX_W-1:0] idx;
  logic               is_last;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic               ram_rdata;

  assign occupancy = {1'b0, q_count} + (CW + 1)'(s1_valid);
  assign in_ready  = !clr_busy && (occupancy < (CW + 1)'(QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;
  assign write_acc = accept && (func == FUNC_WRITE);
  assign emit_acc  = accept && (func == FUNC_EMIT);

  assign addr_ext = INDEX_W'(source_address);
  assign in_range = addr_ext < CellsW;

  // position inside the centered window
  assign sx     = $signed(10'(col)) - WinLeftS;
  assign sy     = $signed(10'(row)) - WinTopS;
  assign in_win = (sx >= 0) && (sx < SrcWS) && (sy >= 0) && (sy < SrcHS);
  assign idx    = INDEX_W'(sy[8:0]) * INDEX_W'(SOURCE_WIDTH) + INDEX_W'(sx[8:0]);

  assign is_last = (col == LastCol) && (row == LastRow);

  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = write_acc && in_range;
      ram_waddr = addr_ext[AW-1:0];
      ram_wdata = source_bit;
    end
  end

  mfub_ram #(
    .WIDTH(1),
    .DEPTH(Cells)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (emit_acc),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LastCell) begin
          clr_busy <= 1'b0;
        end
      end
      s1_valid <= emit_acc;
      if (emit_acc) begin
        if (col == LastCol) begin
          col <= '0;
          row <= (row == LastRow) ? '0 : row + RowW'(1);
        end else begin
          col <= col + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      s1_in_win   <= in_win;
      s1_ov_en    <= overlay_enable;
      s1_ov_color <= overlay_color;
      s1_last     <= is_last;
    end
  end

  always_comb begin
    push.valid                = s1_valid;
    push.entry.lit            = s1_in_win && ram_rdata;
    push.entry.overlay_enable = s1_ov_en;
    push.entry.overlay_color  = s1_ov_color;
    push.entry.frame_last     = s1_last;
  end

  a_room : assert property (@(posedge clk) disable iff (rst)
    occupancy <= (CW + 1)'(QUEUE_DEPTH))
    else $error("front overran queue credit");

endmodule : mfub_front
`default_nettype wire

FILE: sv/mfub_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfub_back
// overlay blend, byte swap and output register
// ----------------------------------------------------------------------------
module mfub_back
  import mfub_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire mfub_entry_t        q_entry,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PIXEL_W-1:0]      display_word,
  output logic                    frame_last
);

  logic [7:0]         br;
  logic [7:0]         bg;
  logic [7:0]         alpha;
  logic [8:0]         inv;
  logic [16:0]        r_sum;
  logic [16:0]        g_sum;
  logic [16:0]        b_sum;
  logic [PIXEL_W-1:0] pix;

  always_comb begin
    br    = q_entry.lit ? 8'hf8 : 8'h00;
    bg    = q_entry.lit ? 8'hfc : 8'h00;
    alpha = {1'b1, q_entry.overlay_color[31:25]};
    inv   = 9'd256 - 9'(alpha);
    r_sum = 17'(br) * 17'(inv) + 17'(q_entry.overlay_color[7:0]) * 17'(alpha);
    g_sum = 17'(bg) * 17'(inv) + 17'(q_entry.overlay_color[15:8]) * 17'(alpha);
    b_sum = 17'(br) * 17'(inv) + 17'(q_entry.overlay_color[23:16]) * 17'(alpha);
    if (q_entry.overlay_enable) begin
      pix = {r_sum[15:11], g_sum[15:10], b_sum[15:11]};
    end else begin
      pix = q_entry.lit ? 16'hffff : 16'h0000;
    end
  end

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      display_word <= {pix[7:0], pix[15:8]};
      frame_last   <= q_entry.frame_last;
    end
  end

endmodule : mfub_back
`default_nettype wire
